// File: rtl/core/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, skipped while reset is high
`define TGSW_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define TGSW_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tgsw_pkg.sv
// shared types and constants for the trilinear shape weight core
`default_nettype none
package tgsw_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned HAT_W    = 17;
  localparam int unsigned INV_W    = 32;
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned GRAD_W   = 49;
  localparam int unsigned ELEM_W   = 24;
  localparam int unsigned NODE_W   = 25;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [HAT_W-1:0] HAT_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMS    = 3'd0,
    REG_CELLS_X = 3'd1,
    REG_CELLS_Y = 3'd2,
    REG_CELLS_Z = 3'd3,
    REG_INV_X   = 3'd4,
    REG_INV_Y   = 3'd5,
    REG_INV_Z   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_AXES-1:0]            used;
    logic [NUM_AXES-1:0]            last_corner;
    logic [NUM_AXES-1:0][INV_W-1:0] inv;
  } cfg_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][HAT_W-1:0] hat;
    logic [NUM_AXES-1:0]            sel;
    logic                           last;
  } corner_t;

endpackage
`default_nettype wire

// File: rtl/core/tgsw_cfg.sv
// configuration registers and values derived from them
`default_nettype none
module tgsw_cfg #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 256,
  parameter int unsigned MAX_DIMS = 3,
  localparam int unsigned NW = $clog2(MAX_CELLS_PER_AXIS + 1),
  localparam int unsigned SW = $clog2(MAX_CELLS_PER_AXIS + 2)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tgsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tgsw_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tgsw_pkg::cfg_t                      cfg,
  output logic [tgsw_pkg::NUM_AXES-1:0][NW-1:0] cnt,
  output logic [2*NW-1:0]                     estr2,
  output logic [SW-1:0]                       ns1,
  output logic [2*SW-1:0]                     ns2
);
  import tgsw_pkg::*;

  logic [1:0]                     dims;
  logic [1:0]                     dims_next;
  logic [NUM_AXES-1:0][8:0]       cells;
  logic [NUM_AXES-1:0][8:0]       cells_next;
  logic [NUM_AXES-1:0][INV_W-1:0] inv;
  logic [NUM_AXES-1:0][INV_W-1:0] inv_next;

  logic [1:0]                     nd;
  logic [NUM_AXES-1:0]            used;
  logic [NUM_AXES-1:0]            used_next;
  logic [NUM_AXES-1:0]            last_corner;
  logic [NUM_AXES-1:0]            last_corner_next;
  logic [NUM_AXES-1:0][NW-1:0]    cnt_next;
  logic [2*NW-1:0]                estr2_next;
  logic [SW-1:0]                  ns1_next;
  logic [SW-1:0]                  ns1y;
  logic [2*SW-1:0]                ns2_next;

  always_comb begin
    dims_next  = dims;
    cells_next = cells;
    inv_next   = inv;
    if (rst) begin
      dims_next = 2'd3;
      for (int a = 0; a < NUM_AXES; a++) begin
        cells_next[a] = 9'd1;
        inv_next[a]   = 32'h0001_0000;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIMS:    dims_next     = cfg_data[1:0];
        REG_CELLS_X: cells_next[0] = cfg_data[8:0];
        REG_CELLS_Y: cells_next[1] = cfg_data[8:0];
        REG_CELLS_Z: cells_next[2] = cfg_data[8:0];
        REG_INV_X:   inv_next[0]   = cfg_data;
        REG_INV_Y:   inv_next[1]   = cfg_data;
        REG_INV_Z:   inv_next[2]   = cfg_data;
        default: ;
      endcase
    end
  end

  // axis count clamp, last corner index, saturated cell counts and index strides
  always_comb begin
    if (dims_next == 2'd0) begin
      nd = 2'd1;
    end else if (32'(dims_next) > MAX_DIMS) begin
      nd = 2'(MAX_DIMS);
    end else begin
      nd = dims_next;
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      used_next[a] = (32'(a) < 32'(nd));
      if (32'(cells_next[a]) > MAX_CELLS_PER_AXIS) begin
        cnt_next[a] = NW'(MAX_CELLS_PER_AXIS);
      end else begin
        cnt_next[a] = NW'(cells_next[a]);
      end
    end
    last_corner_next = 3'((4'd1 << nd) - 4'd1);
    estr2_next = (2*NW)'(cnt_next[0]) * (2*NW)'(cnt_next[1]);
    ns1_next   = SW'(cnt_next[0]) + SW'(1);
    ns1y       = SW'(cnt_next[1]) + SW'(1);
    ns2_next   = (2*SW)'(ns1_next) * (2*SW)'(ns1y);
  end

  always_ff @(posedge clk) begin
    dims        <= dims_next;
    cells       <= cells_next;
    inv         <= inv_next;
    used        <= used_next;
    last_corner <= last_corner_next;
    cnt         <= cnt_next;
    estr2       <= estr2_next;
    ns1         <= ns1_next;
    ns2         <= ns2_next;
  end

  always_comb begin
    cfg.used        = used;
    cfg.last_corner = last_corner;
    cfg.inv         = inv;
  end

endmodule
`default_nettype wire

// File: rtl/core/tgsw_cell_map.sv
// position to cell, fraction and base indices, three register stages
`default_nettype none
module tgsw_cell_map #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 256,
  localparam int unsigned NW = $clog2(MAX_CELLS_PER_AXIS + 1),
  localparam int unsigned SW = $clog2(MAX_CELLS_PER_AXIS + 2),
  localparam int unsigned CW = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1,
  localparam int unsigned EW = 3 * CW,
  localparam int unsigned ND = 3 * SW
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tgsw_pkg::cfg_t                        cfg,
  input  logic [tgsw_pkg::NUM_AXES-1:0][NW-1:0] cnt,
  input  logic [2*NW-1:0]                       estr2,
  input  logic [SW-1:0]                         ns1,
  input  logic [2*SW-1:0]                       ns2,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [tgsw_pkg::POS_W-1:0]     pos_x,
  input  logic signed [tgsw_pkg::POS_W-1:0]     pos_y,
  input  logic signed [tgsw_pkg::POS_W-1:0]     pos_z,
  output logic                                  item_valid,
  input  logic                                  item_ready,
  output logic [EW-1:0]                         elem,
  output logic [ND-1:0]                         nbase,
  output logic [tgsw_pkg::NUM_AXES-1:0][tgsw_pkg::FRAC_W-1:0] frac
);
  import tgsw_pkg::*;

  logic [NUM_AXES-1:0][POS_W-1:0] pos;
  logic [NUM_AXES-1:0][62:0]      prod_in;
  logic [NUM_AXES-1:0]            neg_in;

  logic                           s1_v;
  logic [NUM_AXES-1:0][62:0]      s1_prod;
  logic [NUM_AXES-1:0]            s1_neg;

  logic [NUM_AXES-1:0][30:0]      cell_full;
  logic [NUM_AXES-1:0][CW-1:0]    ci;
  logic                           ok_in;

  logic                           s2_v;
  logic                           s2_ok;
  logic [CW-1:0]                  s2_c0;
  logic [CW+NW-1:0]               s2_e1;
  logic [CW+2*NW-1:0]             s2_e2;
  logic [CW+SW-1:0]               s2_b1;
  logic [CW+2*SW-1:0]             s2_b2;
  logic [NUM_AXES-1:0][FRAC_W-1:0] s2_frac;

  logic                           s3_v;
  logic                           s3_ok;

  logic                           s1_rdy;
  logic                           s2_rdy;
  logic                           s3_rdy;

  assign s3_rdy   = !s3_v || !s3_ok || item_ready;
  assign s2_rdy   = !s2_v || s3_rdy;
  assign s1_rdy   = !s1_v || s2_rdy;
  assign in_ready = s1_rdy;

  assign pos = {pos_z, pos_y, pos_x};

  // unused axes map to cell 0 with fraction 0
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (cfg.used[a]) begin
        prod_in[a] = pos[a][30:0] * cfg.inv[a];
      end else begin
        prod_in[a] = '0;
      end
      neg_in[a] = cfg.used[a] & pos[a][POS_W-1];
    end
  end

  always_comb begin
    ok_in = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      cell_full[a] = s1_prod[a][62:32];
      ci[a]        = cell_full[a][CW-1:0];
      if (cfg.used[a] && (s1_neg[a] || (cell_full[a] >= 31'(cnt[a])))) begin
        ok_in = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v <= in_valid;
      end
      if (s2_rdy) begin
        s2_v <= s1_v;
      end
      if (s3_rdy) begin
        s3_v <= s2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_prod <= prod_in;
      s1_neg  <= neg_in;
    end
    if (s2_rdy) begin
      s2_ok <= ok_in;
      s2_c0 <= ci[0];
      s2_e1 <= (CW+NW)'(ci[1]) * (CW+NW)'(cnt[0]);
      s2_e2 <= (CW+2*NW)'(ci[2]) * (CW+2*NW)'(estr2);
      s2_b1 <= (CW+SW)'(ci[1]) * (CW+SW)'(ns1);
      s2_b2 <= (CW+2*SW)'(ci[2]) * (CW+2*SW)'(ns2);
      for (int a = 0; a < NUM_AXES; a++) begin
        s2_frac[a] <= s1_prod[a][31:16];
      end
    end
    if (s3_rdy) begin
      s3_ok <= s2_ok;
      elem  <= EW'(s2_c0) + EW'(s2_e1) + EW'(s2_e2);
      nbase <= ND'(s2_c0) + ND'(s2_b1) + ND'(s2_b2);
      frac  <= s2_frac;
    end
  end

  assign item_valid = s3_v & s3_ok;

endmodule
`default_nettype wire

// File: rtl/core/tgsw_corner_seq.sv
// walks the element corners of one position, one corner per cycle while issue_ready is high
`default_nettype none
module tgsw_corner_seq #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 256,
  localparam int unsigned SW = $clog2(MAX_CELLS_PER_AXIS + 2),
  localparam int unsigned CW = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1,
  localparam int unsigned EW = 3 * CW,
  localparam int unsigned ND = 3 * SW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tgsw_pkg::cfg_t            cfg,
  input  logic [SW-1:0]             ns1,
  input  logic [2*SW-1:0]           ns2,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [EW-1:0]             elem,
  input  logic [ND-1:0]             nbase,
  input  logic [tgsw_pkg::NUM_AXES-1:0][tgsw_pkg::FRAC_W-1:0] frac,
  output logic                      issue_valid,
  input  logic                      issue_ready,
  output tgsw_pkg::corner_t         corner_out,
  output logic [EW-1:0]             issue_elem,
  output logic [ND-1:0]             issue_node
);
  import tgsw_pkg::*;

  logic                            v;
  logic [NUM_AXES-1:0]             corner;
  logic [EW-1:0]                   elem_q;
  logic [ND-1:0]                   nbase_q;
  logic [NUM_AXES-1:0][FRAC_W-1:0] frac_q;
  logic                            is_last;
  logic                            fire;

  assign is_last     = (corner == cfg.last_corner);
  assign fire        = v & issue_ready;
  assign item_ready  = !v || (fire && is_last);
  assign issue_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v      <= 1'b0;
      corner <= '0;
    end else if (item_ready) begin
      v      <= item_valid;
      corner <= '0;
    end else if (fire) begin
      corner <= corner + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      elem_q  <= elem;
      nbase_q <= nbase;
      frac_q  <= frac;
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      corner_out.sel[a] = corner[a];
      if (corner[a]) begin
        corner_out.hat[a] = {1'b0, frac_q[a]};
      end else begin
        corner_out.hat[a] = HAT_ONE - {1'b0, frac_q[a]};
      end
    end
    corner_out.last = is_last;
    issue_elem = elem_q;
    issue_node = nbase_q + ND'(corner[0])
               + (corner[1] ? ND'(ns1) : ND'(0))
               + (corner[2] ? ND'(ns2) : ND'(0));
  end

endmodule
`default_nettype wire

// File: rtl/core/tgsw_corner_math.sv
// per-corner weight and gradient pipeline with output register
`default_nettype none
module tgsw_corner_math #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 256,
  localparam int unsigned SW = $clog2(MAX_CELLS_PER_AXIS + 2),
  localparam int unsigned CW = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1,
  localparam int unsigned EW = 3 * CW,
  localparam int unsigned ND = 3 * SW
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  tgsw_pkg::cfg_t                          cfg,
  input  logic                                    issue_valid,
  output logic                                    issue_ready,
  input  tgsw_pkg::corner_t                       corner_in,
  input  logic [EW-1:0]                           issue_elem,
  input  logic [ND-1:0]                           issue_node,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [tgsw_pkg::ELEM_W-1:0]             element_index,
  output logic [tgsw_pkg::NODE_W-1:0]             node_index,
  output logic [tgsw_pkg::HAT_W-1:0]              weight,
  output logic signed [tgsw_pkg::GRAD_W-1:0]      grad_x,
  output logic signed [tgsw_pkg::GRAD_W-1:0]      grad_y,
  output logic signed [tgsw_pkg::GRAD_W-1:0]      grad_z,
  output logic                                    last
);
  import tgsw_pkg::*;

  logic                           c1_v;
  corner_t                        c1_c;
  logic [EW-1:0]                  c1_elem;
  logic [ND-1:0]                  c1_node;

  logic                           c2_v;
  logic [HAT_W-1:0]               c2_p01;
  logic [HAT_W-1:0]               c2_p02;
  logic [HAT_W-1:0]               c2_p12;
  logic [HAT_W-1:0]               c2_h2;
  logic [NUM_AXES-1:0]            c2_sel;
  logic                           c2_last;
  logic [EW-1:0]                  c2_elem;
  logic [ND-1:0]                  c2_node;

  logic                           c3_v;
  logic [HAT_W-1:0]               c3_w;
  logic [NUM_AXES-1:0][MAG_W-1:0] c3_mag;
  logic [NUM_AXES-1:0]            c3_sel;
  logic                           c3_last;
  logic [EW-1:0]                  c3_elem;
  logic [ND-1:0]                  c3_node;

  logic [33:0]                    t01;
  logic [33:0]                    t02;
  logic [33:0]                    t12;
  logic [33:0]                    tw;
  logic [NUM_AXES-1:0][HAT_W-1:0] g;
  logic [NUM_AXES-1:0][48:0]      tm;
  logic [NUM_AXES-1:0][GRAD_W-1:0] grad_next;

  logic                           out_rdy;
  logic                           c3_rdy;
  logic                           c2_rdy;
  logic                           c1_rdy;

  assign out_rdy     = !out_valid || !out_stall;
  assign c3_rdy      = !c3_v || out_rdy;
  assign c2_rdy      = !c2_v || c3_rdy;
  assign c1_rdy      = !c1_v || c2_rdy;
  assign issue_ready = c1_rdy;

  // pairwise hat products
  always_comb begin
    t01 = c1_c.hat[0] * c1_c.hat[1];
    t02 = c1_c.hat[0] * c1_c.hat[2];
    t12 = c1_c.hat[1] * c1_c.hat[2];
  end

  // weight and gradient magnitudes
  always_comb begin
    tw   = c2_p01 * c2_h2;
    g[0] = c2_p12;
    g[1] = c2_p02;
    g[2] = c2_p01;
    for (int a = 0; a < NUM_AXES; a++) begin
      tm[a] = g[a] * cfg.inv[a];
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!cfg.used[a]) begin
        grad_next[a] = '0;
      end else if (c3_sel[a]) begin
        grad_next[a] = GRAD_W'(c3_mag[a]);
      end else begin
        grad_next[a] = GRAD_W'(0) - GRAD_W'(c3_mag[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v      <= 1'b0;
      c2_v      <= 1'b0;
      c3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c1_rdy) begin
        c1_v <= issue_valid;
      end
      if (c2_rdy) begin
        c2_v <= c1_v;
      end
      if (c3_rdy) begin
        c3_v <= c2_v;
      end
      if (out_rdy) begin
        out_valid <= c3_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c1_rdy) begin
      c1_c    <= corner_in;
      c1_elem <= issue_elem;
      c1_node <= issue_node;
    end
    if (c2_rdy) begin
      c2_p01  <= t01[32:16];
      c2_p02  <= t02[32:16];
      c2_p12  <= t12[32:16];
      c2_h2   <= c1_c.hat[2];
      c2_sel  <= c1_c.sel;
      c2_last <= c1_c.last;
      c2_elem <= c1_elem;
      c2_node <= c1_node;
    end
    if (c3_rdy) begin
      c3_w    <= tw[32:16];
      for (int a = 0; a < NUM_AXES; a++) begin
        c3_mag[a] <= tm[a][47:16];
      end
      c3_sel  <= c2_sel;
      c3_last <= c2_last;
      c3_elem <= c2_elem;
      c3_node <= c2_node;
    end
    if (out_rdy) begin
      element_index <= ELEM_W'(c3_elem);
      node_index    <= NODE_W'(c3_node);
      weight        <= c3_w;
      grad_x        <= $signed(grad_next[0]);
      grad_y        <= $signed(grad_next[1]);
      grad_z        <= $signed(grad_next[2]);
      last          <= c3_last;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/trilinear_grid_shape_weights_core.sv
// first corner result passes the cell map, sequencer, corner math and output registers
// throughput: one corner per cycle while no stage is stalled, set by the corner sequencer
// feeding the weight and gradient stages; a position has 2, 4 or 8 corners for 1, 2 or 3 axes
// positions outside the grid are dropped in the front stages and never reach the sequencer
// reset clears all valid bits and loads the default configuration
`default_nettype none
module trilinear_grid_shape_weights_core #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 256,
  parameter int unsigned MAX_DIMS = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tgsw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgsw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tgsw_pkg::POS_W-1:0]    pos_x,
  input  logic signed [tgsw_pkg::POS_W-1:0]    pos_y,
  input  logic signed [tgsw_pkg::POS_W-1:0]    pos_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tgsw_pkg::ELEM_W-1:0]          element_index,
  output logic [tgsw_pkg::NODE_W-1:0]          node_index,
  output logic [tgsw_pkg::HAT_W-1:0]           weight,
  output logic signed [tgsw_pkg::GRAD_W-1:0]   grad_x,
  output logic signed [tgsw_pkg::GRAD_W-1:0]   grad_y,
  output logic signed [tgsw_pkg::GRAD_W-1:0]   grad_z,
  output logic                                 last
);
  import tgsw_pkg::*;

  localparam int unsigned NW = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int unsigned SW = $clog2(MAX_CELLS_PER_AXIS + 2);
  localparam int unsigned CW = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
  localparam int unsigned EW = 3 * CW;
  localparam int unsigned ND = 3 * SW;

  cfg_t                            cfg;
  logic [NUM_AXES-1:0][NW-1:0]     cnt;
  logic [2*NW-1:0]                 estr2;
  logic [SW-1:0]                   ns1;
  logic [2*SW-1:0]                 ns2;

  logic                            in_ready;
  logic                            item_valid;
  logic                            item_ready;
  logic [EW-1:0]                   item_elem;
  logic [ND-1:0]                   item_nbase;
  logic [NUM_AXES-1:0][FRAC_W-1:0] item_frac;

  logic                            issue_valid;
  logic                            issue_ready;
  corner_t                         issue_corner;
  logic [EW-1:0]                   issue_elem;
  logic [ND-1:0]                   issue_node;

  assign in_stall = !in_ready;

  tgsw_cfg #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS),
    .MAX_DIMS(MAX_DIMS)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg),
    .cnt(cnt),
    .estr2(estr2),
    .ns1(ns1),
    .ns2(ns2)
  );

  tgsw_cell_map #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_cell_map (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cnt(cnt),
    .estr2(estr2),
    .ns1(ns1),
    .ns2(ns2),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .elem(item_elem),
    .nbase(item_nbase),
    .frac(item_frac)
  );

  tgsw_corner_seq #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_corner_seq (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .ns1(ns1),
    .ns2(ns2),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .elem(item_elem),
    .nbase(item_nbase),
    .frac(item_frac),
    .issue_valid(issue_valid),
    .issue_ready(issue_ready),
    .corner_out(issue_corner),
    .issue_elem(issue_elem),
    .issue_node(issue_node)
  );

  tgsw_corner_math #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_corner_math (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .issue_valid(issue_valid),
    .issue_ready(issue_ready),
    .corner_in(issue_corner),
    .issue_elem(issue_elem),
    .issue_node(issue_node),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .element_index(element_index),
    .node_index(node_index),
    .weight(weight),
    .grad_x(grad_x),
    .grad_y(grad_y),
    .grad_z(grad_z),
    .last(last)
  );

endmodule
`default_nettype wire

// File: rtl/core/tgsw_checker.sv
// port-level checker for the trilinear shape weight core, with its bind
`default_nettype none
`include "assert_macros.svh"
module tgsw_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] element_index,
  input logic [24:0] node_index,
  input logic [16:0] weight,
  input logic [48:0] grad_x,
  input logic [48:0] grad_y,
  input logic [48:0] grad_z,
  input logic        last
);

  `TGSW_ASSERT_NR(a_rst_empty, clk, rst |=> !out_valid, "output valid after reset")

  `TGSW_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable({element_index, node_index, weight, last}), "stalled result changed")

  `TGSW_ASSERT(a_weight_max, clk, rst, out_valid |-> weight <= 17'h10000, "weight above one")

  `TGSW_ASSERT(a_grad_x_range, clk, rst, out_valid |-> (grad_x[48:32] == 17'h0 || grad_x[48:32] == 17'h1ffff), "grad_x out of range")

  `TGSW_ASSERT(a_grad_yz_range, clk, rst, out_valid |-> ((grad_y[48:32] == 17'h0 || grad_y[48:32] == 17'h1ffff) && (grad_z[48:32] == 17'h0 || grad_z[48:32] == 17'h1ffff)), "grad_y or grad_z out of range")

endmodule

bind trilinear_grid_shape_weights_core tgsw_checker u_tgsw_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .element_index(element_index),
  .node_index(node_index),
  .weight(weight),
  .grad_x(grad_x),
  .grad_y(grad_y),
  .grad_z(grad_z),
  .last(last)
);
`default_nettype wire
